// ----- src/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants
// opcode codes, status codes, controller command and datapath status structs
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int MEM_WORDS   = 32768;
  localparam int STACK_DEPTH = 256;
  localparam int NUM_REGS    = 8;

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int SCW = SPW + 1;
  localparam int RW  = $clog2(NUM_REGS);

  localparam logic [14:0] PC_MASK = 15'h7fff;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_BADOP = 3'd2;
  localparam logic [2:0] ST_NOIN  = 3'd3;
  localparam logic [2:0] ST_UNDER = 3'd4;
  localparam logic [2:0] ST_OVER  = 3'd5;

  localparam logic [15:0] OP_HALT = 16'd0;
  localparam logic [15:0] OP_SET  = 16'd1;
  localparam logic [15:0] OP_PUSH = 16'd2;
  localparam logic [15:0] OP_POP  = 16'd3;
  localparam logic [15:0] OP_EQ   = 16'd4;
  localparam logic [15:0] OP_GT   = 16'd5;
  localparam logic [15:0] OP_JMP  = 16'd6;
  localparam logic [15:0] OP_JT   = 16'd7;
  localparam logic [15:0] OP_JF   = 16'd8;
  localparam logic [15:0] OP_ADD  = 16'd9;
  localparam logic [15:0] OP_MULT = 16'd10;
  localparam logic [15:0] OP_MOD  = 16'd11;
  localparam logic [15:0] OP_AND  = 16'd12;
  localparam logic [15:0] OP_OR   = 16'd13;
  localparam logic [15:0] OP_NOT  = 16'd14;
  localparam logic [15:0] OP_RMEM = 16'd15;
  localparam logic [15:0] OP_WMEM = 16'd16;
  localparam logic [15:0] OP_CALL = 16'd17;
  localparam logic [15:0] OP_RET  = 16'd18;
  localparam logic [15:0] OP_OUT  = 16'd19;
  localparam logic [15:0] OP_IN   = 16'd20;
  localparam logic [15:0] OP_NOOP = 16'd21;

  // memory read address source
  typedef enum logic [1:0] {
    MA_PC   = 2'd0,
    MA_PCK  = 2'd1,
    MA_OPB  = 2'd2
  } mem_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic        load;       // capture input word
    logic        mem_wr_in;  // write memory from input word
    logic        mem_rd;     // issue memory read
    mem_sel_t    mem_sel;
    logic [1:0]  fetch_k;    // instruction word offset
    logic        cap_op;     // capture fetched words
    logic [1:0]  cap_idx;
    logic        cap_data;   // capture rmem data
    logic        stk_rd;     // issue stack read at top
    logic        div_start;
    logic        exec;       // commit instruction
    logic        res_load;   // load result register
  } cmd_t;

  // datapath status to controller
  typedef struct packed {
    logic        is_step;
    logic        running;
    logic [15:0] opcode;
    logic        div_busy;
  } sts_t;

endpackage

// ----- src/svm_div.sv -----
// ----------------------------------------------------------------------------
// svm_div: iterative remainder unit
// restoring division, one quotient bit a cycle, remainder only
// ----------------------------------------------------------------------------
module svm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] rem
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] dvs_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[15]} - {1'b0, dvs_r};
    if (start) begin
      rem_nxt = 16'd0;
      quo_nxt = dividend;
      cnt_nxt = 5'd16;
    end else if (cnt_r != 5'd0) begin
      quo_nxt = {quo_r[14:0], 1'b0};
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
      end else begin
        rem_nxt = {rem_r[14:0], quo_r[15]};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy = (cnt_r != 5'd0);
  assign rem  = (dvs_r == 16'd0) ? 16'd0 : rem_r;

endmodule

// ----- src/svm_datapath.sv -----
// ----------------------------------------------------------------------------
// svm_datapath: machine state and execution datapath
// memory, registers, stack, pc, stop code, operand decode and result register
// ----------------------------------------------------------------------------
module svm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  svm_pkg::cmd_t       cmd,
  output svm_pkg::sts_t       sts,
  input  logic                in_op,
  input  logic [14:0]         in_addr,
  input  logic [15:0]         in_data,
  input  logic [7:0]          in_ch,
  input  logic                in_chv,
  output logic [2:0]          res_status,
  output logic [14:0]         res_pc,
  output logic                res_outv,
  output logic [7:0]          res_outc,
  output logic                res_taken
);

  logic [15:0] mem [svm_pkg::MEM_WORDS];
  logic [15:0] stk [svm_pkg::STACK_DEPTH];
  logic [15:0] regs_r [svm_pkg::NUM_REGS];

  logic        op_r;
  logic [14:0] addr_r;
  logic [15:0] data_r;
  logic [7:0]  ch_r;
  logic        chv_r;

  logic [15:0] mdat_r;
  logic [15:0] stkd_r;
  logic [15:0] w_r [4];
  logic [15:0] rdat_r;
  logic [svm_pkg::SCW-1:0] sc_r;
  logic [14:0] pc_r;
  logic [2:0]  stop_r;

  logic [15:0] opa, opb, opc;
  logic [14:0] rd_addr;
  logic [15:0] div_rem;
  logic        div_busy;
  logic [14:0] prod;
  logic        do_ex;

  function automatic logic [15:0] opnd(input logic [15:0] w,
                                       input logic [15:0] rf [svm_pkg::NUM_REGS]);
    logic [15:0] v;
    v = w[15] ? rf[w[svm_pkg::RW-1:0]] : w;
    return v;
  endfunction

  assign opa = opnd(w_r[1], regs_r);
  assign opb = opnd(w_r[2], regs_r);
  assign opc = opnd(w_r[3], regs_r);

  assign do_ex = cmd.exec && op_r && (stop_r == svm_pkg::ST_RUN);

  always_comb begin
    case (cmd.mem_sel)
      svm_pkg::MA_PCK: rd_addr = pc_r + {13'd0, cmd.fetch_k};
      svm_pkg::MA_OPB: rd_addr = opb[14:0];
      default:         rd_addr = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr_in) begin
      mem[addr_r[svm_pkg::AW-1:0]] <= data_r;
    end else if (do_ex && w_r[0] == svm_pkg::OP_WMEM) begin
      mem[opa[svm_pkg::AW-1:0]] <= opb;
    end
    if (cmd.mem_rd) begin
      mdat_r <= mem[rd_addr[svm_pkg::AW-1:0]];
    end
  end

  assign prod = opb[14:0] * opc[14:0];

  svm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (opb),
    .divisor  (opc),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // execute stage
  logic [15:0] wv;
  logic        wen, push, pop, outv, tkn;
  logic [14:0] npc;
  logic [2:0]  st;
  logic [15:0] pushv;
  logic        full, empty;

  assign full  = (sc_r >= svm_pkg::SCW'(svm_pkg::STACK_DEPTH));
  assign empty = (sc_r == '0) || (sc_r > svm_pkg::SCW'(svm_pkg::STACK_DEPTH));

  always_comb begin
    wv = 16'd0; wen = 1'b0; push = 1'b0; pop = 1'b0; outv = 1'b0; tkn = 1'b0;
    npc = pc_r; st = svm_pkg::ST_RUN; pushv = opa;
    unique case (w_r[0])
      svm_pkg::OP_HALT: st = svm_pkg::ST_HALT;
      svm_pkg::OP_SET: begin
        wen = 1'b1; wv = opb; npc = pc_r + 15'd3;
      end
      svm_pkg::OP_PUSH: begin
        if (full) begin
          st = svm_pkg::ST_OVER;
        end else begin
          push = 1'b1; npc = pc_r + 15'd2;
        end
      end
      svm_pkg::OP_POP: begin
        if (empty) begin
          st = svm_pkg::ST_UNDER;
        end else begin
          pop = 1'b1; wen = 1'b1; wv = stkd_r; npc = pc_r + 15'd2;
        end
      end
      svm_pkg::OP_EQ: begin
        wen = 1'b1; wv = {15'd0, opb == opc}; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_GT: begin
        wen = 1'b1; wv = {15'd0, opb > opc}; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_JMP: npc = opa[14:0];
      svm_pkg::OP_JT:  npc = (opa != 16'd0) ? opb[14:0] : pc_r + 15'd3;
      svm_pkg::OP_JF:  npc = (opa == 16'd0) ? opb[14:0] : pc_r + 15'd3;
      svm_pkg::OP_ADD: begin
        wen = 1'b1; wv = {1'b0, opb[14:0] + opc[14:0]}; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_MULT: begin
        wen = 1'b1; wv = {1'b0, prod[14:0]}; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_MOD: begin
        wen = 1'b1; wv = div_rem; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_AND: begin
        wen = 1'b1; wv = opb & opc; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_OR: begin
        wen = 1'b1; wv = opb | opc; npc = pc_r + 15'd4;
      end
      svm_pkg::OP_NOT: begin
        wen = 1'b1; wv = {1'b0, ~opb[14:0]}; npc = pc_r + 15'd3;
      end
      svm_pkg::OP_RMEM: begin
        wen = 1'b1; wv = rdat_r; npc = pc_r + 15'd3;
      end
      svm_pkg::OP_WMEM: npc = pc_r + 15'd3;
      svm_pkg::OP_CALL: begin
        if (full) begin
          st = svm_pkg::ST_OVER;
        end else begin
          push = 1'b1; pushv = {1'b0, pc_r + 15'd2}; npc = opa[14:0];
        end
      end
      svm_pkg::OP_RET: begin
        if (empty) begin
          st = svm_pkg::ST_UNDER;
        end else begin
          pop = 1'b1; npc = stkd_r[14:0];
        end
      end
      svm_pkg::OP_OUT: begin
        outv = 1'b1; npc = pc_r + 15'd2;
      end
      svm_pkg::OP_IN: begin
        if (!chv_r) begin
          st = svm_pkg::ST_NOIN;
        end else begin
          wen = 1'b1; wv = {8'd0, ch_r}; tkn = 1'b1; npc = pc_r + 15'd2;
        end
      end
      svm_pkg::OP_NOOP: npc = pc_r + 15'd1;
      default: st = svm_pkg::ST_BADOP;
    endcase
    if (st != svm_pkg::ST_RUN) begin
      wen = 1'b0; push = 1'b0; pop = 1'b0; outv = 1'b0; tkn = 1'b0; npc = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push && do_ex) begin
      stk[sc_r[svm_pkg::SPW-1:0]] <= pushv;
    end
    if (cmd.stk_rd) begin
      stkd_r <= stk[svm_pkg::SPW'(sc_r - svm_pkg::SCW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < svm_pkg::NUM_REGS; i++) begin
        regs_r[i] <= 16'd0;
      end
      sc_r      <= '0;
      pc_r      <= 15'd0;
      stop_r    <= svm_pkg::ST_RUN;
      res_outv  <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      if (do_ex) begin
        if (wen) begin
          regs_r[w_r[1][svm_pkg::RW-1:0]] <= wv;
        end
        if (push) begin
          sc_r <= sc_r + svm_pkg::SCW'(1);
        end else if (pop) begin
          sc_r <= sc_r - svm_pkg::SCW'(1);
        end
        pc_r   <= npc;
        stop_r <= st;
      end
      if (cmd.res_load) begin
        res_outv  <= do_ex && outv;
        res_taken <= do_ex && tkn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; addr_r <= in_addr; data_r <= in_data; ch_r <= in_ch; chv_r <= in_chv;
    end
    if (cmd.cap_op) begin
      w_r[cmd.cap_idx] <= mdat_r;
    end
    if (cmd.cap_data) begin
      rdat_r <= mdat_r;
    end
    if (cmd.res_load) begin
      res_outc <= (do_ex && outv) ? opa[7:0] : 8'd0;
    end
  end

  // status and pc reflect the state after the commit
  assign res_status = stop_r;
  assign res_pc     = pc_r;

  assign sts.is_step  = op_r;
  assign sts.running  = (stop_r == svm_pkg::ST_RUN);
  assign sts.opcode   = w_r[0];
  assign sts.div_busy = div_busy;

endmodule

// ----- src/svm_ctrl.sv -----
// ----------------------------------------------------------------------------
// svm_ctrl: instruction sequencer
// steps fetch, operand read, mod divide and commit per accepted step word
// ----------------------------------------------------------------------------
module svm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_busy,
  input  logic          out_fire,
  input  svm_pkg::sts_t sts,
  output svm_pkg::cmd_t cmd,
  output logic          idle,
  output logic          res_set
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_CAP   = 9'b000001000,
    S_RMEM  = 9'b000010000,
    S_RCAP  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_EXEC  = 9'b010000000,
    S_WAIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    res_set   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.is_step) begin
          cmd.mem_wr_in = 1'b1;
          state_nxt     = S_EXEC;
        end else if (!sts.running) begin
          state_nxt = S_EXEC;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.mem_rd  = 1'b1;
        cmd.mem_sel = svm_pkg::MA_PCK;
        cmd.fetch_k = k_r;
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cmd.cap_op  = 1'b1;
        cmd.cap_idx = k_r;
        k_nxt       = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = S_RMEM;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_RMEM: begin
        cmd.mem_rd  = 1'b1;
        cmd.mem_sel = svm_pkg::MA_OPB;
        cmd.stk_rd  = 1'b1;
        state_nxt   = S_RCAP;
      end
      S_RCAP: begin
        cmd.cap_data = 1'b1;
        if (sts.opcode == svm_pkg::OP_MOD) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_busy) begin
          cmd.exec     = 1'b1;
          cmd.res_load = 1'b1;
          res_set      = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

endmodule

// ----- src/stack_vm_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor: sixteen-bit word stack machine
//
// channel  dir  fields (low bit up)
// in_*     in   tdata: address[14:0] data[30:15] in_char[38:31] in_valid[39];
//               tuser: operation
// out_*    out  tdata: status[2:0] next_pc[17:3] out_valid[18] out_char[26:19]
//               char_taken[27]
//
// a load word goes from accept through decode to result; a step is paced
// by four sequential single-port memory fetches plus an operand read,
// and mod also waits on the bit-serial remainder unit
// one word at a time: in_tready is high only when the sequencer is idle
// a result holds in the output register until out_tready takes it
// reset clears registers, stack count, pc and stop code; memory is not cleared
// ----------------------------------------------------------------------------
module stack_vm_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // address, data, in_char, in_valid
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status, next_pc, out_valid, out_char, char_taken
);

  svm_pkg::cmd_t cmd;
  svm_pkg::sts_t sts;
  logic        idle, res_set, in_fire, out_fire;
  logic        ov_r;
  logic [2:0]  r_st;
  logic [14:0] r_pc;
  logic        r_ov, r_tk;
  logic [7:0]  r_oc;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (ov_r),
    .out_fire (out_fire),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle),
    .res_set  (res_set)
  );

  svm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_addr    (in_tdata[14:0]),
    .in_data    (in_tdata[30:15]),
    .in_ch      (in_tdata[38:31]),
    .in_chv     (in_tdata[39]),
    .res_status (r_st),
    .res_pc     (r_pc),
    .res_outv   (r_ov),
    .res_outc   (r_oc),
    .res_taken  (r_tk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_set) begin
      ov_r <= 1'b1;
    end else if (out_fire) begin
      ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, r_tk, r_oc, r_ov, r_pc, r_st};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != svm_pkg::ST_RUN) |=> out_tdata[2:0] != svm_pkg::ST_RUN)
    else $error("stop code cleared");

endmodule
